[src/pmd_pkg.sv]
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared constants, word type and saturating add and subtract for the
// projection matrix decomposition block.
// ----------------------------------------------------------------------------
package pmd_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int WORD_WIDTH = 48;
   localparam int IDX_W      = 4;
   localparam int NUM_ELEM   = 12;
   localparam int TDATA_W    = ((IDX_W + WORD_WIDTH + 7) / 8) * 8;

   typedef logic signed [WORD_WIDTH-1:0] word_type;

   localparam word_type WMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam word_type WMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   function automatic word_type sat_add(word_type a, word_type b);
      logic [WORD_WIDTH:0] s;
      s = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
      if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) begin
         return s[WORD_WIDTH] ? WMIN : WMAX;
      end
      return s[WORD_WIDTH-1:0];
   endfunction

   function automatic word_type sat_sub(word_type a, word_type b);
      logic [WORD_WIDTH:0] s;
      s = {a[WORD_WIDTH-1], a} - {b[WORD_WIDTH-1], b};
      if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) begin
         return s[WORD_WIDTH] ? WMIN : WMAX;
      end
      return s[WORD_WIDTH-1:0];
   endfunction

endpackage

[src/pmd_mul.sv]
// ----------------------------------------------------------------------------
// pmd_mul
// Fixed point multiplier: four half-width partial products, one after
// another, then rounding half away from zero and saturation.
// ----------------------------------------------------------------------------
module pmd_mul import pmd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type op_a,
   input  word_type op_b,
   output logic     done,
   output word_type prod
);

   localparam int HALF_W = (WORD_WIDTH + 1) / 2;
   localparam int PROD_W = 4 * HALF_W;

   logic [2*HALF_W-1:0] a_mag_ff, a_mag_in, b_mag_ff, b_mag_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic                neg_ff, neg_in;
   logic [2:0]          step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   word_type            prod_ff, prod_in;

   always_comb begin
      logic [HALF_W-1:0]   ah, bh;
      logic [2*HALF_W-1:0] pp;
      logic [PROD_W-1:0]   sh, t, q;
      logic [WORD_WIDTH-1:0] ma, mb;
      a_mag_in = a_mag_ff;
      b_mag_in = b_mag_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      prod_in  = prod_ff;
      ma = op_a[WORD_WIDTH-1] ? WORD_WIDTH'(-op_a) : WORD_WIDTH'(op_a);
      mb = op_b[WORD_WIDTH-1] ? WORD_WIDTH'(-op_b) : WORD_WIDTH'(op_b);
      ah = step_ff[0] ? a_mag_ff[2*HALF_W-1:HALF_W] : a_mag_ff[HALF_W-1:0];
      bh = step_ff[1] ? b_mag_ff[2*HALF_W-1:HALF_W] : b_mag_ff[HALF_W-1:0];
      pp = ah * bh;
      unique case (step_ff[1:0])
         2'b00:          sh = PROD_W'(pp);
         2'b01, 2'b10:   sh = PROD_W'(pp) << HALF_W;
         default:        sh = PROD_W'(pp) << (2 * HALF_W);
      endcase
      t = acc_ff + (PROD_W'(1) << (FRAC_BITS - 1));
      q = t >> FRAC_BITS;
      if (start) begin
         a_mag_in = (2*HALF_W)'(ma);
         b_mag_in = (2*HALF_W)'(mb);
         neg_in   = op_a[WORD_WIDTH-1] ^ op_b[WORD_WIDTH-1];
         acc_in   = '0;
         step_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (step_ff[2]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (|q[PROD_W-1:WORD_WIDTH-1]) begin
               prod_in = neg_ff ? WMIN : WMAX;
            end else begin
               prod_in = neg_ff ? -word_type'(q[WORD_WIDTH-1:0])
                                : word_type'(q[WORD_WIDTH-1:0]);
            end
         end else begin
            acc_in  = acc_ff + sh;
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      a_mag_ff <= a_mag_in;
      b_mag_ff <= b_mag_in;
      acc_ff   <= acc_in;
      neg_ff   <= neg_in;
      prod_ff  <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

[src/pmd_sqrt.sv]
// ----------------------------------------------------------------------------
// pmd_sqrt
// Digit-by-digit square root, two radicand bits a cycle, of x scaled by
// 2^FRAC_BITS, floored and saturated.
// ----------------------------------------------------------------------------
module pmd_sqrt import pmd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type radicand,
   output logic     done,
   output word_type root
);

   localparam int SQ_N  = (WORD_WIDTH + FRAC_BITS + 1) / 2;
   localparam int RAD_W = 2 * SQ_N;
   localparam int CNT_W = $clog2(SQ_N + 1);
   localparam int CMP_W = SQ_N + WORD_WIDTH;

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [SQ_N+1:0]   rem_ff, rem_in;
   logic [SQ_N-1:0]   root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   word_type          res_ff, res_in;

   always_comb begin
      logic [SQ_N+1:0] r2, trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      r2    = {rem_ff[SQ_N-1:0], rad_ff[RAD_W-1:RAD_W-2]};
      trial = {root_ff, 2'b01};
      if (start) begin
         rad_in  = RAD_W'({radicand, {FRAC_BITS{1'b0}}});
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(SQ_N);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (r2 >= trial) begin
            rem_in  = r2 - trial;
            root_in = {root_ff[SQ_N-2:0], 1'b1};
         end else begin
            rem_in  = r2;
            root_in = {root_ff[SQ_N-2:0], 1'b0};
         end
         rad_in = rad_ff << 2;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (CMP_W'(root_in) > CMP_W'(WMAX)) begin
               res_in = WMAX;
            end else begin
               res_in = WORD_WIDTH'(root_in);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      res_ff  <= res_in;
   end

   assign done = done_ff;
   assign root = res_ff;

endmodule

[src/pmd_div.sv]
// ----------------------------------------------------------------------------
// pmd_div
// Restoring divider, one quotient bit a cycle: (num * 2^FRAC_BITS) / den
// for a positive den, magnitude rounded half away from zero, saturated.
// ----------------------------------------------------------------------------
module pmd_div import pmd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type num,
   input  word_type den,
   output logic     done,
   output word_type quot
);

   localparam int DN    = WORD_WIDTH + FRAC_BITS;
   localparam int CNT_W = $clog2(DN + 1);

   logic [DN-1:0]         num_ff, num_in;
   logic [DN-1:0]         q_ff, q_in;
   logic [WORD_WIDTH:0]   rem_ff, rem_in;
   logic [WORD_WIDTH-1:0] den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   word_type              res_ff, res_in;

   always_comb begin
      logic [WORD_WIDTH:0]   r2;
      logic [WORD_WIDTH-1:0] m;
      logic                  rnd;
      logic [DN:0]           qr;
      num_in  = num_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      m   = num[WORD_WIDTH-1] ? WORD_WIDTH'(-num) : WORD_WIDTH'(num);
      r2  = {rem_ff[WORD_WIDTH-1:0], num_ff[DN-1]};
      rnd = {rem_ff[WORD_WIDTH-1:0], 1'b0} >= {1'b0, den_ff};
      qr  = (DN+1)'(q_ff) + (DN+1)'(rnd);
      if (start) begin
         num_in  = {m, {FRAC_BITS{1'b0}}};
         q_in    = '0;
         rem_in  = '0;
         den_in  = den;
         neg_in  = num[WORD_WIDTH-1];
         cnt_in  = CNT_W'(DN);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (qr > (DN+1)'(WMAX)) begin
               res_in = neg_ff ? WMIN : WMAX;
            end else begin
               res_in = neg_ff ? -word_type'(qr[WORD_WIDTH-1:0])
                               : word_type'(qr[WORD_WIDTH-1:0]);
            end
         end else begin
            if (r2 >= {1'b0, den_ff}) begin
               rem_in = r2 - {1'b0, den_ff};
               q_in   = {q_ff[DN-2:0], 1'b1};
            end else begin
               rem_in = r2;
               q_in   = {q_ff[DN-2:0], 1'b0};
            end
            num_in = num_ff << 1;
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign quot = res_ff;

endmodule

[src/projection_matrix_decompose.sv]
// ----------------------------------------------------------------------------
// projection_matrix_decompose
// Splits a 3x4 camera projection matrix into scales, principal point and
// two extrinsic rows, in signed Q24.24.
// ----------------------------------------------------------------------------
// Elements load one beat a cycle while the block is idle. The beat with
// tlast starts the decomposition, during which req_tready is low. The
// time goes on 22 fixed point products on a shared multiplier (the eight
// extrinsic ones reload a stored element first), two square roots, eight
// divisions on a one-bit-a-cycle divider, and a sequencing state and an
// issue state for each of the twelve result beats. A held result beat
// stalls the next one. A bad matrix skips the roots, the extrinsic
// products and the divisions, gives twelve zero beats with tuser set and
// keeps req_tready low until the last of them is issued.
module projection_matrix_decompose import pmd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,  // element_index, element_value, zero pad
   input  logic               req_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,  // result_index, result_value, zero pad
   output logic               rsp_tuser,  // matrix_invalid
   output logic               rsp_tlast
);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_LDC  = 10'b0000000010,
      ST_LDA  = 10'b0000000100,
      ST_LDB  = 10'b0000001000,
      ST_MUL  = 10'b0000010000,
      ST_ACC  = 10'b0000100000,
      ST_NEXT = 10'b0001000000,
      ST_SQRT = 10'b0010000000,
      ST_DIV  = 10'b0100000000,
      ST_EMIT = 10'b1000000000
   } state_type;

   typedef enum logic [2:0] {
      JOB_DOT = 3'b001,
      JOB_SQ  = 3'b010,
      JOB_OUT = 3'b100
   } job_type;

   word_type   pstore_ff [NUM_ELEM];
   state_type  state_ff, state_in;
   job_type    job_ff, job_in;
   logic [1:0] d_ff, d_in, j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   word_type   acc_ff, acc_in, opa_ff, opa_in, opb_ff, opb_in, res_ff, res_in;
   word_type   dot_ff [4], dot_in [4];
   word_type   scale_ff [2], scale_in [2];
   word_type   alpha_ff [2], alpha_in [2];
   logic       bad_ff, bad_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   word_type         rsp_val_ff, rsp_val_in;
   logic             rsp_bad_ff, rsp_bad_in, rsp_last_ff, rsp_last_in;

   logic [IDX_W-1:0] rd_addr;
   word_type         rd_data;
   logic [IDX_W-1:0] req_idx;
   word_type         req_val;
   logic             mul_start, mul_done, sq_start, sq_done, div_start, div_done;
   word_type         mul_prod, sq_res, div_num, div_res;

   assign req_idx    = req_tdata[IDX_W-1:0];
   assign req_val    = req_tdata[IDX_W +: WORD_WIDTH];
   assign req_tready = (state_ff == ST_IDLE);
   assign rd_data    = pstore_ff[rd_addr];

   pmd_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (opa_ff),
      .op_b  (opb_in),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   pmd_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (scale_ff[k_ff[0]]),
      .done     (sq_done),
      .root     (sq_res)
   );

   pmd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (alpha_ff[k_ff[3]]),
      .done  (div_done),
      .quot  (div_res)
   );

   always_comb begin
      logic [1:0] r2b, s2b;
      word_type   val;
      state_in     = state_ff;
      job_in       = job_ff;
      d_in         = d_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      res_in       = res_ff;
      dot_in       = dot_ff;
      scale_in     = scale_ff;
      alpha_in     = alpha_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_last_in  = rsp_last_ff;
      rd_addr      = '0;
      mul_start    = 1'b0;
      sq_start     = 1'b0;
      div_start    = 1'b0;
      div_num      = acc_ff;
      r2b = {1'b0, d_ff[0]};
      s2b = d_ff[1] ? {1'b0, d_ff[0]} : 2'd2;
      val = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tlast) begin
               job_in   = JOB_DOT;
               d_in     = '0;
               j_in     = '0;
               acc_in   = '0;
               state_in = ST_LDA;
            end
         end
         ST_LDC: begin
            rd_addr  = {1'b0, k_ff[3], k_ff[1:0]};
            acc_in   = rd_data;
            state_in = ST_LDA;
         end
         ST_LDA: begin
            unique case (job_ff)
               JOB_DOT: begin
                  rd_addr = {r2b, j_ff};
                  opa_in  = rd_data;
               end
               JOB_SQ:  opa_in = dot_ff[{1'b0, d_ff[0]}];
               default: opa_in = dot_ff[{1'b0, k_ff[3]}];
            endcase
            state_in = ST_LDB;
         end
         ST_LDB: begin
            unique case (job_ff)
               JOB_DOT: begin
                  rd_addr = {s2b, j_ff};
                  opb_in  = rd_data;
               end
               JOB_SQ:  opb_in = opa_ff;
               default: begin
                  rd_addr = {2'd2, k_ff[1:0]};
                  opb_in  = rd_data;
               end
            endcase
            mul_start = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            unique case (job_ff)
               JOB_DOT: begin
                  val = sat_add(acc_ff, mul_prod);
                  state_in = ST_LDA;
                  if (j_ff == 2'd2) begin
                     dot_in[d_ff] = val;
                     j_in = '0;
                     if (d_ff == 2'd3) begin
                        job_in = JOB_SQ;
                        d_in   = '0;
                        acc_in = dot_ff[2];
                     end else begin
                        d_in   = d_ff + 2'd1;
                        acc_in = '0;
                     end
                  end else begin
                     acc_in = val;
                     j_in   = j_ff + 2'd1;
                  end
               end
               JOB_SQ: begin
                  val = sat_sub(acc_ff, mul_prod);
                  scale_in[d_ff[0]] = val;
                  if (d_ff[0] == 1'b0) begin
                     d_in     = 2'd1;
                     acc_in   = dot_ff[3];
                     state_in = ST_LDA;
                  end else begin
                     bad_in = scale_ff[0][WORD_WIDTH-1] || (scale_ff[0] == '0) ||
                              val[WORD_WIDTH-1] || (val == '0);
                     k_in     = '0;
                     job_in   = JOB_OUT;
                     state_in = ST_NEXT;
                  end
               end
               default: begin
                  div_num   = sat_sub(acc_ff, mul_prod);
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            endcase
         end
         ST_NEXT: begin
            priority if (bad_ff) begin
               res_in   = '0;
               state_in = ST_EMIT;
            end else if (k_ff < IDX_W'(2)) begin
               sq_start = 1'b1;
               state_in = ST_SQRT;
            end else if (k_ff < IDX_W'(4)) begin
               res_in   = dot_ff[{1'b0, k_ff[0]}];
               state_in = ST_EMIT;
            end else begin
               state_in = ST_LDC;
            end
         end
         ST_SQRT: begin
            if (sq_done) begin
               res_in             = sq_res;
               alpha_in[k_ff[0]]  = sq_res;
               state_in           = ST_EMIT;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = div_res;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = k_ff;
               rsp_val_in   = res_ff;
               rsp_bad_in   = bad_ff;
               rsp_last_in  = (k_ff == IDX_W'(NUM_ELEM - 1));
               if (k_ff == IDX_W'(NUM_ELEM - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = ST_NEXT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= JOB_DOT;
         rsp_valid_ff <= 1'b0;
         d_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         bad_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         rsp_valid_ff <= rsp_valid_in;
         d_ff         <= d_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         bad_ff       <= bad_in;
      end
      acc_ff      <= acc_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      res_ff      <= res_in;
      dot_ff      <= dot_in;
      scale_ff    <= scale_in;
      alpha_ff    <= alpha_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_bad_ff  <= rsp_bad_in;
      rsp_last_ff <= rsp_last_in;
   end

   // store the element beat
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready && (req_idx < IDX_W'(NUM_ELEM))) begin
         pstore_ff[req_idx] <= req_val;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'({rsp_val_ff, rsp_idx_ff});
   assign rsp_tuser  = rsp_bad_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[tb/sv/projection_matrix_decompose_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// projection_matrix_decompose_test
// Loads 3x4 projection matrices element by element, with the last element
// marked by tlast, and checks every result beat of the decomposition
// against a predictor run on the same beats. Valid and invalid matrices,
// out-of-range indices and saturating values are covered, and both sides
// of the stream idle at random in several phases.
// ----------------------------------------------------------------------------
module projection_matrix_decompose_test;
   import pmd_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      word_type         value;
      logic             last;
   } load_beat_t;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      word_type         value;
      logic             invalid;
      logic             last;
   } result_beat_t;

   localparam int PAD_W = TDATA_W - IDX_W - WORD_WIDTH;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata = '0;
   logic               req_tlast = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;
   logic               rsp_tuser;
   logic               rsp_tlast;

   load_beat_t   pending_loads[$];
   result_beat_t expected_results[$];
   word_type     shadow_matrix[NUM_ELEM];
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           fail_count = 0;
   int           matrices_done = 0;
   int           invalid_seen = 0;
   int           beats_checked = 0;

   projection_matrix_decompose uut (.*);

   always #1 clock = ~clock;

   function automatic word_type clamp_mag(logic neg, logic [127:0] m);
      if (m >= (128'd1 << (WORD_WIDTH - 1))) return neg ? WMIN : WMAX;
      return neg ? -$signed(m[WORD_WIDTH-1:0]) : $signed(m[WORD_WIDTH-1:0]);
   endfunction

   function automatic logic [127:0] magnitude(word_type a);
      logic [127:0] m;
      m = {{(128 - WORD_WIDTH){a[WORD_WIDTH-1]}}, a};
      return a[WORD_WIDTH-1] ? -m : m;
   endfunction

   function automatic word_type fix_mul(word_type a, word_type b);
      logic [127:0] p;
      p = magnitude(a) * magnitude(b);
      p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return clamp_mag(a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1], p);
   endfunction

   function automatic word_type fix_sqrt(word_type x);
      logic [127:0] target, root, trial;
      target = magnitude(x) << FRAC_BITS;
      root = '0;
      for (int bit_pos = 63; bit_pos >= 0; bit_pos--) begin
         trial = root | (128'd1 << bit_pos);
         if (trial * trial <= target) root = trial;
      end
      return clamp_mag(1'b0, root);
   endfunction

   function automatic word_type fix_div(word_type num, word_type den);
      logic [127:0] n, d, q, r;
      n = magnitude(num) << FRAC_BITS;
      d = magnitude(den);
      q = n / d;
      r = n % d;
      if ((r << 1) >= d) q = q + 1;
      return clamp_mag(num[WORD_WIDTH-1], q);
   endfunction

   function automatic word_type row_dot(int r, int s);
      word_type acc;
      acc = '0;
      for (int j = 0; j < 3; j++)
         acc = sat_add(acc, fix_mul(shadow_matrix[r*4+j], shadow_matrix[s*4+j]));
      return acc;
   endfunction

   task automatic predict_decomposition(load_beat_t b);
      word_type vals[NUM_ELEM];
      word_type u0, v0, au, av, p2;
      logic bad;
      result_beat_t res;
      if (b.index < NUM_ELEM) shadow_matrix[b.index] = b.value;
      if (!b.last) return;
      u0 = row_dot(0, 2);
      v0 = row_dot(1, 2);
      au = sat_sub(row_dot(0, 0), fix_mul(u0, u0));
      av = sat_sub(row_dot(1, 1), fix_mul(v0, v0));
      bad = (au <= 0) || (av <= 0);
      for (int k = 0; k < NUM_ELEM; k++) vals[k] = '0;
      if (!bad) begin
         au = fix_sqrt(au);
         av = fix_sqrt(av);
         vals[0] = au;
         vals[1] = av;
         vals[2] = u0;
         vals[3] = v0;
         for (int j = 0; j < 4; j++) begin
            p2 = shadow_matrix[8+j];
            vals[4+j] = fix_div(sat_sub(shadow_matrix[j], fix_mul(u0, p2)), au);
            vals[8+j] = fix_div(sat_sub(shadow_matrix[4+j], fix_mul(v0, p2)), av);
         end
      end
      for (int k = 0; k < NUM_ELEM; k++) begin
         res.index = IDX_W'(k);
         res.value = vals[k];
         res.invalid = bad;
         res.last = (k == NUM_ELEM - 1);
         expected_results.push_back(res);
      end
   endtask

   function automatic word_type random_word();
      return word_type'({$urandom, $urandom});
   endfunction

   function automatic word_type random_element(int mode);
      case (mode)
         0: return random_word();
         1: return $signed(48'($urandom_range(0, 1 << 26))) - (48'sd1 << 25);
         default: return $signed(48'($urandom)) >>> $urandom_range(0, 12);
      endcase
   endfunction

   task automatic queue_load(int idx, word_type v, logic last);
      load_beat_t b;
      b.index = IDX_W'(idx);
      b.value = v;
      b.last = last;
      pending_loads.push_back(b);
   endtask

   // plausible camera: scaled rotation-like rows keep the squared scales positive
   task automatic queue_camera(int mode);
      word_type one;
      one = 48'sd1 << FRAC_BITS;
      for (int i = 0; i < NUM_ELEM; i++) begin
         if (mode == 0) begin
            if (i == 0 || i == 5) queue_load(i, one * word_type'($urandom_range(1, 900))
                                                + random_element(1), i == 11);
            else if (i == 10) queue_load(i, one + (random_element(1) >>> 4), i == 11);
            else if (i == 8 || i == 9) queue_load(i, random_element(1) >>> 3, i == 11);
            else queue_load(i, random_element(1) << $urandom_range(0, 6), i == 11);
         end else begin
            queue_load(i, random_element(mode), i == 11);
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_loads.size() != 0 || expected_results.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (900) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         if (!req_tvalid || req_tready) begin
            if (req_tvalid) predict_decomposition(pending_loads.pop_front());
            if (pending_loads.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= {{PAD_W{1'b0}}, pending_loads[0].value, pending_loads[0].index};
               req_tlast <= pending_loads[0].last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      result_beat_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_checked++;
         if (expected_results.size() == 0) begin
            $error("unexpected result beat index %0d", rsp_tdata[IDX_W-1:0]);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[IDX_W-1:0] !== want.index) begin
               $error("result_index expected %0d actual %0d", want.index,
                      rsp_tdata[IDX_W-1:0]);
               fail_count++;
            end
            if ($signed(rsp_tdata[IDX_W+WORD_WIDTH-1:IDX_W]) !== want.value) begin
               $error("result_value expected %0d actual %0d", want.value,
                      $signed(rsp_tdata[IDX_W+WORD_WIDTH-1:IDX_W]));
               fail_count++;
            end
            if (rsp_tuser !== want.invalid) begin
               $error("matrix_invalid expected %0b actual %0b", want.invalid, rsp_tuser);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_result expected %0b actual %0b", want.last, rsp_tlast);
               fail_count++;
            end
            if (want.last) matrices_done++;
            if (want.last && want.invalid) invalid_seen++;
         end
      end
   end

   initial begin
      int phase_idle[4];
      int phase_stall[4];
      word_type one;
      phase_idle = '{0, 69, 0, 23};
      phase_stall = '{0, 0, 69, 23};
      one = 48'sd1 << FRAC_BITS;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // directed: identity-like camera, then extremes and invalid cases
      for (int i = 0; i < NUM_ELEM; i++)
         queue_load(i, (i == 0 || i == 5 || i == 10) ? one : '0, i == 11);
      queue_load(3, WMAX, 1'b0);
      queue_load(7, WMIN, 1'b0);
      queue_load(13, WMAX, 1'b0);
      queue_load(15, WMIN, 1'b1);
      queue_load(0, WMAX, 1'b0);
      queue_load(1, WMIN, 1'b0);
      queue_load(12, '0, 1'b1);
      queue_load(0, '0, 1'b0);
      queue_load(5, '0, 1'b1);
      queue_load(14, 48'sh5555_5555_5555, 1'b1);
      wait_drained();
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = phase_idle[p];
         recv_stall_pct = phase_stall[p];
         for (int m = 0; m < 3; m++) begin
            if ($urandom_range(0, 9) < 7) queue_camera(0);
            else if ($urandom_range(0, 1) != 0) queue_camera($urandom_range(1, 2));
            else begin
               for (int n = 0; n < 4; n++)
                  queue_load($urandom_range(0, 15), random_element(0),
                             1'($urandom_range(0, 1)));
            end
         end
         wait_drained();
      end
      $display("Checked %0d result beats over %0d matrices, %0d of them invalid.",
               beats_checked, matrices_done, invalid_seen);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
src/pmd_pkg.sv
src/pmd_mul.sv
src/pmd_sqrt.sv
src/pmd_div.sv
src/projection_matrix_decompose.sv
tb/sv/projection_matrix_decompose_test.sv
